[rtl/core/gsdp_pkg.sv]
package gsdp_pkg;

   localparam int LANES_DEF           = 8;
   localparam int MAX_ROW_LENGTH_DEF  = 4096;
   localparam int SCALE_FRAC_BITS_DEF = 16;

   localparam int LANE_W     = 8;
   localparam int PROD_W     = 16;
   localparam int WORD_W     = 64;
   localparam int BYTE_LANES = WORD_W / LANE_W;
   localparam int SCALE_W    = 24;
   localparam int VALUE_W    = 64;
   localparam int GS_W       = 9;
   localparam int RL_W       = 13;
   localparam int RC_W       = 17;
   localparam int ROW_IDX_W  = 16;
   localparam int CSR_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int RSP_DEPTH  = 8;

   localparam logic [GS_W-1:0] GS_RESET = GS_W'(32);
   localparam logic [RL_W-1:0] RL_RESET = RL_W'(256);
   localparam logic [RC_W-1:0] RC_RESET = RC_W'(1);

   localparam int PROD_MAX_MAG = 16384;
   localparam int GSUM_W_DEF =
      $clog2((MAX_ROW_LENGTH_DEF + LANES_DEF) * PROD_MAX_MAG + 1) + 1;

   localparam logic [VALUE_W-1:0] ACC_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] ACC_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GROUP_LEN,
      CSR_ROW_LENGTH,
      CSR_ROW_COUNT
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic close;
      logic row_end;
      logic last;
   } tag_type;

   typedef struct packed {
      logic [SCALE_W-1:0] act;
      logic [SCALE_W-1:0] wgt;
   } scale_type;

   typedef struct packed {
      tag_type            tag;
      logic               clip;
      logic               neg;
      logic [VALUE_W-1:0] value;
   } term_type;

endpackage

[rtl/core/gsdp_lane.sv]
module gsdp_lane import gsdp_pkg::*; (
   input  logic                     clock,
   input  logic [LANE_W-1:0]        act,
   input  logic [LANE_W-1:0]        wgt,
   output logic signed [PROD_W-1:0] product_ff
);

   logic signed [PROD_W-1:0] product_in;

   assign product_in = PROD_W'($signed(act)) * PROD_W'($signed(wgt));

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

[rtl/core/gsdp_merge.sv]
module gsdp_merge import gsdp_pkg::*; #(
   parameter int N_LANES = LANES_DEF,
   parameter int GSUM_W  = GSUM_W_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tag_type                  s1_tag,
   input  scale_type                s1_scale,
   input  logic signed [PROD_W-1:0] product [N_LANES],
   output tag_type                  s2_tag_ff,
   output scale_type                s2_scale_ff,
   output logic signed [GSUM_W-1:0] s2_total_ff
);

   logic signed [GSUM_W-1:0] item_sum;
   logic signed [GSUM_W-1:0] total;
   logic signed [GSUM_W-1:0] group_sum_ff;
   logic signed [GSUM_W-1:0] group_sum_in;

   always_comb begin
      item_sum = '0;
      for (int i = 0; i < N_LANES; i++) begin
         item_sum = item_sum + GSUM_W'(product[i]);
      end
      total        = group_sum_ff + item_sum;
      group_sum_in = group_sum_ff;
      if (s1_tag.valid) begin
         group_sum_in = s1_tag.close ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_sum_ff <= '0;
         s2_tag_ff    <= '0;
      end else begin
         group_sum_ff <= group_sum_in;
         s2_tag_ff    <= s1_tag;
      end
   end

   always_ff @(posedge clock) begin
      s2_scale_ff <= s1_scale;
      s2_total_ff <= total;
   end

endmodule

[rtl/core/gsdp_fold.sv]
module gsdp_fold import gsdp_pkg::*; #(
   parameter int GSUM_W          = GSUM_W_DEF,
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tag_type                  s2_tag,
   input  scale_type                s2_scale,
   input  logic signed [GSUM_W-1:0] s2_total,
   output term_type                 term_ff
);

   localparam int MAG_W = GSUM_W - 1;
   localparam int M1_W  = MAG_W + SCALE_W;
   localparam int ML_W  = 32;
   localparam int MH_W  = M1_W - ML_W;
   localparam int PL_W  = ML_W + SCALE_W;
   localparam int PH_W  = MH_W + SCALE_W;
   localparam int P_W   = M1_W + SCALE_W;
   localparam int Q_W   = P_W - SCALE_FRAC_BITS;
   localparam int QX_W  = (Q_W > VALUE_W - 1 ? Q_W : VALUE_W - 1) + 1;

   logic signed [GSUM_W-1:0] total_abs;
   logic [M1_W-1:0]          m1_in;
   logic [PL_W-1:0]          pl_in;
   logic [PH_W-1:0]          ph_in;
   logic [P_W-1:0]           prod_in;
   logic [QX_W-1:0]          qx;
   logic                     rem;
   logic                     inc;
   term_type                 term_in;

   tag_type                  s3_tag_ff;
   logic                     s3_neg_ff;
   logic [SCALE_W-1:0]       s3_act_ff;
   logic [M1_W-1:0]          s3_m1_ff;
   tag_type                  s4_tag_ff;
   logic                     s4_neg_ff;
   logic [PL_W-1:0]          s4_pl_ff;
   logic [PH_W-1:0]          s4_ph_ff;
   tag_type                  s5_tag_ff;
   logic                     s5_neg_ff;
   logic [P_W-1:0]           s5_prod_ff;

   // Magnitude times weight scale, then times activation scale in two halves.
   always_comb begin
      total_abs = s2_total[GSUM_W-1] ? -s2_total : s2_total;
      m1_in     = M1_W'(total_abs[MAG_W-1:0]) * M1_W'(s2_scale.wgt);
      pl_in     = PL_W'(s3_m1_ff[ML_W-1:0]) * PL_W'(s3_act_ff);
      ph_in     = PH_W'(s3_m1_ff[M1_W-1:ML_W]) * PH_W'(s3_act_ff);
      prod_in   = P_W'(s4_pl_ff) + (P_W'(s4_ph_ff) << ML_W);
   end

   // The shift floors, so a negative term with dropped bits grows by one.
   always_comb begin
      qx            = QX_W'(s5_prod_ff[P_W-1:SCALE_FRAC_BITS]);
      rem           = |s5_prod_ff[SCALE_FRAC_BITS-1:0];
      inc           = s5_neg_ff && rem;
      term_in.tag   = s5_tag_ff;
      term_in.neg   = s5_neg_ff;
      term_in.clip  = (|qx[QX_W-1:VALUE_W-1]) || ((&qx[VALUE_W-2:0]) && inc);
      term_in.value = s5_neg_ff ? (~qx[VALUE_W-1:0] + VALUE_W'(!rem)) : qx[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
         s5_tag_ff <= '0;
         term_ff   <= '0;
      end else begin
         s3_tag_ff <= s2_tag;
         s4_tag_ff <= s3_tag_ff;
         s5_tag_ff <= s4_tag_ff;
         term_ff   <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_neg_ff  <= s2_total[GSUM_W-1];
      s3_act_ff  <= s2_scale.act;
      s3_m1_ff   <= m1_in;
      s4_neg_ff  <= s3_neg_ff;
      s4_pl_ff   <= pl_in;
      s4_ph_ff   <= ph_in;
      s5_neg_ff  <= s4_neg_ff;
      s5_prod_ff <= prod_in;
   end

endmodule

[rtl/core/gsdp_accum.sv]
module gsdp_accum import gsdp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  term_type                  term,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_row_value,
   output logic                      rsp_saturated,
   output logic                      rsp_last_row
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               sat;
      logic               last;
   } entry_type;

   logic [VALUE_W-1:0] acc_ff;
   logic [VALUE_W-1:0] acc_in;
   logic               sat_ff;
   logic               sat_in;
   logic [VALUE_W-1:0] acc_new;
   logic               sat_new;
   logic [VALUE_W-1:0] sum;
   logic               add_ovf;
   logic               push;
   logic               pop;
   entry_type          entry_mem [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   always_comb begin
      sum     = acc_ff + term.value;
      add_ovf = (acc_ff[VALUE_W-1] == term.value[VALUE_W-1])
                && (sum[VALUE_W-1] != acc_ff[VALUE_W-1]);
      acc_new = acc_ff;
      sat_new = sat_ff;
      if (term.tag.valid && term.tag.close) begin
         if (term.clip) begin
            acc_new = term.neg ? ACC_MIN : ACC_MAX;
            sat_new = 1'b1;
         end else if (add_ovf) begin
            acc_new = term.value[VALUE_W-1] ? ACC_MIN : ACC_MAX;
            sat_new = 1'b1;
         end else begin
            acc_new = sum;
         end
      end
      push   = term.tag.valid && term.tag.row_end;
      pop    = rsp_valid && !rsp_stall;
      acc_in = push ? '0 : acc_new;
      sat_in = push ? 1'b0 : sat_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         sat_ff    <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         acc_ff    <= acc_in;
         sat_ff    <= sat_in;
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_mem[wr_ptr_ff] <= '{value: acc_new, sat: sat_new, last: term.tag.last};
      end
   end

   assign rsp_valid     = count_ff != '0;
   assign rsp_row_value = $signed(entry_mem[rd_ptr_ff].value);
   assign rsp_saturated = entry_mem[rd_ptr_ff].sat;
   assign rsp_last_row  = entry_mem[rd_ptr_ff].last;

endmodule

[rtl/core/group_scaled_int8_dot_product.sv]
// Streams the rows of a weight matrix, one word of eight signed 8-bit activation and weight
// lanes per cycle while the input is not stalled, and returns one Q.16 row value per row
// with a saturation flag and a last-row flag. Each lane multiplies in parallel and a merging
// stage adds the lane products into the group sum; the closing word of a group supplies the
// two Q8.16 scales. A row's result passes from the lane product registers through the
// merge stage, the fold stages and the term register into the output queue. Up to eight
// results may be outstanding in the pipeline and the output queue; beyond that the input is
// stalled until a result is taken. A write to the group length register stalls the input
// while a bit-serial remainder unit recomputes the position within the group, one bit of
// the element position (twelve at the default maximum row length) at a time.
module group_scaled_int8_dot_product import gsdp_pkg::*; #(
   parameter int LANES           = LANES_DEF,
   parameter int MAX_ROW_LENGTH  = MAX_ROW_LENGTH_DEF,
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [WORD_W-1:0]         req_act_lanes,
   input  logic [WORD_W-1:0]         req_wgt_lanes,
   input  logic [SCALE_W-1:0]        req_act_scale,
   input  logic [SCALE_W-1:0]        req_wgt_scale,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_row_value,
   output logic                      rsp_saturated,
   output logic                      rsp_last_row,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   localparam int ACT_LANES = LANES < BYTE_LANES ? LANES : BYTE_LANES;
   localparam int GSUM_W    = $clog2((MAX_ROW_LENGTH + LANES) * PROD_MAX_MAG + 1) + 1;
   localparam int EPW       = $clog2(MAX_ROW_LENGTH);
   localparam int IDX_W     = $clog2(EPW);
   localparam int PSW       = $clog2(MAX_ROW_LENGTH + LANES);
   localparam int RLC_W     = $clog2(MAX_ROW_LENGTH + 1);
   localparam int CW0       = PSW > RLC_W ? PSW : RLC_W;
   localparam int CW        = CW0 > RL_W ? CW0 : RL_W;
   localparam int QB        = $clog2(LANES + 1);
   localparam int XW        = GS_W + QB;
   localparam int PEND_W    = $clog2(RSP_DEPTH + 1);

   logic [GS_W-1:0]          gs_ff;
   logic [RL_W-1:0]          rl_ff;
   logic [RC_W-1:0]          rc_ff;
   logic [EPW-1:0]           ep_ff;
   logic [GS_W-1:0]          grp_rem_ff;
   logic [ROW_IDX_W-1:0]     row_idx_ff;
   logic [PEND_W-1:0]        pending_ff;
   logic [PEND_W-1:0]        pending_in;
   logic                     busy_ff;
   logic [IDX_W-1:0]         div_idx_ff;
   logic [GS_W-1:0]          div_rem_ff;
   tag_type                  s1_tag_ff;
   scale_type                s1_scale_ff;

   logic                     accept;
   logic [PSW-1:0]           pos;
   logic [CW-1:0]            rl_ext;
   logic [CW-1:0]            rl_lim;
   logic                     row_end;
   logic [XW-1:0]            rx;
   logic [XW-1:0]            rd;
   logic [GS_W-1:0]          grp_rem_next;
   logic                     grp_close;
   logic                     last;
   logic [GS_W:0]            div_t;
   logic [GS_W-1:0]          div_next;
   logic                     gs_write;

   logic signed [PROD_W-1:0] product [ACT_LANES];
   tag_type                  s2_tag;
   scale_type                s2_scale;
   logic signed [GSUM_W-1:0] s2_total;
   term_type                 term;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff || (pending_ff == PEND_W'(RSP_DEPTH));
   assign gs_write  = csr_wr_en && (csr_index == CSR_GROUP_LEN);

   always_comb begin
      pos     = PSW'(ep_ff) + PSW'(LANES);
      rl_ext  = CW'(rl_ff);
      rl_lim  = (rl_ext > CW'(MAX_ROW_LENGTH)) ? CW'(MAX_ROW_LENGTH) : rl_ext;
      row_end = CW'(pos) >= rl_lim;

      // Position within the group after this word, kept without a divider.
      rx = XW'(grp_rem_ff) + XW'(LANES);
      for (int k = QB - 1; k >= 0; k--) begin
         rd = XW'(gs_ff) << k;
         if (rx >= rd) begin
            rx = rx - rd;
         end
      end
      grp_rem_next = rx[GS_W-1:0];
      grp_close    = row_end || ((gs_ff != '0) && (grp_rem_next == '0));
      last         = (RC_W'(row_idx_ff) + RC_W'(1)) >= rc_ff;

      div_t = {div_rem_ff, ep_ff[div_idx_ff]};
      if (div_t >= {1'b0, gs_ff}) begin
         div_t = div_t - {1'b0, gs_ff};
      end
      div_next = div_t[GS_W-1:0];

      pending_in = pending_ff + PEND_W'(accept && row_end) - PEND_W'(rsp_valid && !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff      <= GS_RESET;
         rl_ff      <= RL_RESET;
         rc_ff      <= RC_RESET;
         ep_ff      <= '0;
         grp_rem_ff <= '0;
         row_idx_ff <= '0;
         pending_ff <= '0;
         busy_ff    <= 1'b0;
         div_idx_ff <= '0;
         div_rem_ff <= '0;
         s1_tag_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GROUP_LEN:  gs_ff <= csr_wdata[GS_W-1:0];
               CSR_ROW_LENGTH: rl_ff <= csr_wdata[RL_W-1:0];
               CSR_ROW_COUNT:  rc_ff <= csr_wdata[RC_W-1:0];
               default: ;
            endcase
         end
         if (gs_write) begin
            busy_ff    <= 1'b1;
            div_idx_ff <= IDX_W'(EPW - 1);
            div_rem_ff <= '0;
         end else if (busy_ff) begin
            div_rem_ff <= div_next;
            if (div_idx_ff == '0) begin
               busy_ff    <= 1'b0;
               grp_rem_ff <= div_next;
            end else begin
               div_idx_ff <= div_idx_ff - IDX_W'(1);
            end
         end
         if (accept) begin
            ep_ff      <= row_end ? '0 : pos[EPW-1:0];
            grp_rem_ff <= row_end ? '0 : grp_rem_next;
            if (row_end) begin
               row_idx_ff <= last ? '0 : row_idx_ff + ROW_IDX_W'(1);
            end
         end
         s1_tag_ff  <= '{valid: accept, close: grp_close, row_end: row_end, last: last};
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_scale_ff <= '{act: req_act_scale, wgt: req_wgt_scale};
   end

   for (genvar g = 0; g < ACT_LANES; g++) begin : g_lane
      gsdp_lane u_lane (
         .clock      (clock),
         .act        (req_act_lanes[g*LANE_W +: LANE_W]),
         .wgt        (req_wgt_lanes[g*LANE_W +: LANE_W]),
         .product_ff (product[g])
      );
   end

   gsdp_merge #(
      .N_LANES (ACT_LANES),
      .GSUM_W  (GSUM_W)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .s1_tag      (s1_tag_ff),
      .s1_scale    (s1_scale_ff),
      .product     (product),
      .s2_tag_ff   (s2_tag),
      .s2_scale_ff (s2_scale),
      .s2_total_ff (s2_total)
   );

   gsdp_fold #(
      .GSUM_W          (GSUM_W),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_fold (
      .clock    (clock),
      .reset    (reset),
      .s2_tag   (s2_tag),
      .s2_scale (s2_scale),
      .s2_total (s2_total),
      .term_ff  (term)
   );

   gsdp_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .term          (term),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_row_value (rsp_row_value),
      .rsp_saturated (rsp_saturated),
      .rsp_last_row  (rsp_last_row)
   );

   // A queued result always has a credit outstanding for it.
   a_rsp_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("result word offered without an outstanding credit");

   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && row_end) |=> ((ep_ff == '0) && (grp_rem_ff == '0)))
      else $error("row state not cleared after the closing word of a row");

   a_group_pos: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && (gs_ff != '0)) |-> (grp_rem_ff < gs_ff))
      else $error("position within the group is not below the group size");

endmodule
